>>> rtl/imhdk_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// imhdk_pkg
// Shared types and constants of the indexed min-heap core.
// ----------------------------------------------------------------------------
package imhdk_pkg;

  localparam int MaxVertices = 256;
  localparam int VertexBits  = 8;
  localparam int PosBits     = 9;
  localparam int KeyBits     = 32;
  localparam int CountBits   = 9;

  typedef enum logic [1:0] {
    FUNC_LOAD    = 2'd0,
    FUNC_EXTRACT = 2'd1,
    FUNC_DEC_KEY = 2'd2,
    FUNC_MEMBER  = 2'd3
  } func_t;

  typedef enum logic [1:0] {
    ST_OK          = 2'd0,
    ST_EMPTY       = 2'd1,
    ST_ABSENT      = 2'd2,
    ST_NOT_SMALLER = 2'd3
  } status_t;

  // datapath micro-operations issued by the controller
  typedef enum logic [4:0] {
    OP_NONE,
    OP_LOAD,
    OP_X1,
    OP_X2,
    OP_X3,
    OP_X4,
    OP_X5,
    OP_D1,
    OP_D2,
    OP_D3,
    OP_D4,
    OP_D5,
    OP_K1,
    OP_K2,
    OP_K3,
    OP_U1,
    OP_U2,
    OP_U3,
    OP_U4,
    OP_FIN
  } dp_op_t;

  typedef struct packed {
    logic   accept;
    dp_op_t op;
  } cmd_t;

  typedef struct packed {
    func_t func;
    logic  ld_more;
    logic  empty;
    logic  no_child;
    logic  keep;
    logic  present;
    logic  smaller;
    logic  at_root;
    logic  parent_ok;
    logic  out_free;
  } stat_t;

endpackage
`default_nettype wire

>>> rtl/indexed_min_heap_decrease_key_core.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// indexed_min_heap_decrease_key_core
// Indexed binary min-heap with load, extract-min, decrease-key and membership.
//
// channel  | handshake           | payload
// ---------+---------------------+--------------------------------------------
// input    | in_valid / in_stall | func, vertex, key
// output   | out_valid/out_stall | status, out_vertex, out_key, in_heap,
//          |                     | heap_empty
// config   | cfg_wr_en           | cfg_wr_data (vertex_count)
//
// one operation at a time; the three heap memories have one read port each
// load fills min(vertex_count, 256) entries; an empty extract goes to result
// extract sifts down level by level until no child is left or a key compare
// ends the walk; decrease-key sifts up until the root or the parent compare
// stops it; membership and rejected decrease-key end after the key lookup
// synchronous reset clears control and size; memory contents are not cleared
// a new item is taken while the previous result waits under out_stall
// ----------------------------------------------------------------------------
module indexed_min_heap_decrease_key_core (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             cfg_wr_en,
  input  wire logic [imhdk_pkg::CountBits-1:0]  cfg_wr_data,
  input  wire logic                             in_valid,
  output logic                                  in_stall,
  input  wire logic [1:0]                       func,
  input  wire logic [imhdk_pkg::VertexBits-1:0] vertex,
  input  wire logic [imhdk_pkg::KeyBits-1:0]    key,
  output logic                                  out_valid,
  input  wire logic                             out_stall,
  output logic [1:0]                            status,
  output logic [imhdk_pkg::VertexBits-1:0]      out_vertex,
  output logic [imhdk_pkg::KeyBits-1:0]         out_key,
  output logic                                  in_heap,
  output logic                                  heap_empty
);

  imhdk_pkg::cmd_t  cmd;
  imhdk_pkg::stat_t st;

  imhdk_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .st       (st),
    .cmd      (cmd)
  );

  imhdk_dp u_dp (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .func        (func),
    .vertex      (vertex),
    .key         (key),
    .cmd         (cmd),
    .st          (st),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .status      (status),
    .out_vertex  (out_vertex),
    .out_key     (out_key),
    .in_heap     (in_heap),
    .heap_empty  (heap_empty)
  );

endmodule
`default_nettype wire

>>> rtl/imhdk_ram.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// imhdk_ram
// Generic single write, single read RAM with registered read data.
// ----------------------------------------------------------------------------
module imhdk_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

>>> rtl/imhdk_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// imhdk_ctrl
// Controller: sequences load, extract with sift-down, and key lookup with
// sift-up over the datapath.
// ----------------------------------------------------------------------------
module imhdk_ctrl (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             in_valid,
  output logic                  in_stall,
  input  wire imhdk_pkg::stat_t st,
  output imhdk_pkg::cmd_t       cmd
);

  typedef enum logic [19:0] {
    S_IDLE = 20'h00001,
    S_LOAD = 20'h00002,
    S_X1   = 20'h00004,
    S_X2   = 20'h00008,
    S_X3   = 20'h00010,
    S_X4   = 20'h00020,
    S_X5   = 20'h00040,
    S_D1   = 20'h00080,
    S_D2   = 20'h00100,
    S_D3   = 20'h00200,
    S_D4   = 20'h00400,
    S_D5   = 20'h00800,
    S_K1   = 20'h01000,
    S_K2   = 20'h02000,
    S_K3   = 20'h04000,
    S_U1   = 20'h08000,
    S_U2   = 20'h10000,
    S_U3   = 20'h20000,
    S_U4   = 20'h40000,
    S_FIN  = 20'h80000
  } state_t;

  state_t state;
  state_t state_next;
  logic   accept;

  assign in_stall = rst || (state != S_IDLE);
  assign accept   = in_valid && !in_stall;

  always_comb begin
    state_next = state;
    cmd.accept = accept;
    cmd.op     = imhdk_pkg::OP_NONE;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          unique case (st.func)
            imhdk_pkg::FUNC_LOAD:    state_next = S_LOAD;
            imhdk_pkg::FUNC_EXTRACT: state_next = st.empty ? S_FIN : S_X1;
            imhdk_pkg::FUNC_DEC_KEY,
            imhdk_pkg::FUNC_MEMBER:  state_next = S_K1;
            default:                 state_next = S_IDLE;
          endcase
        end
      end
      S_LOAD: begin
        cmd.op = imhdk_pkg::OP_LOAD;
        if (!st.ld_more) state_next = S_FIN;
      end
      S_X1: begin cmd.op = imhdk_pkg::OP_X1; state_next = S_X2; end
      S_X2: begin cmd.op = imhdk_pkg::OP_X2; state_next = S_X3; end
      S_X3: begin cmd.op = imhdk_pkg::OP_X3; state_next = S_X4; end
      S_X4: begin cmd.op = imhdk_pkg::OP_X4; state_next = S_X5; end
      S_X5: begin cmd.op = imhdk_pkg::OP_X5; state_next = S_D1; end
      S_D1: begin
        cmd.op     = imhdk_pkg::OP_D1;
        state_next = st.no_child ? S_FIN : S_D2;
      end
      S_D2: begin cmd.op = imhdk_pkg::OP_D2; state_next = S_D3; end
      S_D3: begin cmd.op = imhdk_pkg::OP_D3; state_next = S_D4; end
      S_D4: begin
        cmd.op     = imhdk_pkg::OP_D4;
        state_next = st.keep ? S_FIN : S_D5;
      end
      S_D5: begin cmd.op = imhdk_pkg::OP_D5; state_next = S_D1; end
      S_K1: begin cmd.op = imhdk_pkg::OP_K1; state_next = S_K2; end
      S_K2: begin cmd.op = imhdk_pkg::OP_K2; state_next = S_K3; end
      S_K3: begin
        cmd.op = imhdk_pkg::OP_K3;
        if (st.func == imhdk_pkg::FUNC_DEC_KEY && st.present && st.smaller) begin
          state_next = S_U1;
        end else begin
          state_next = S_FIN;
        end
      end
      S_U1: begin
        cmd.op     = imhdk_pkg::OP_U1;
        state_next = st.at_root ? S_FIN : S_U2;
      end
      S_U2: begin cmd.op = imhdk_pkg::OP_U2; state_next = S_U3; end
      S_U3: begin
        cmd.op     = imhdk_pkg::OP_U3;
        state_next = st.parent_ok ? S_FIN : S_U4;
      end
      S_U4: begin cmd.op = imhdk_pkg::OP_U4; state_next = S_U1; end
      S_FIN: begin
        cmd.op = imhdk_pkg::OP_FIN;
        if (st.out_free) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule
`default_nettype wire

>>> rtl/imhdk_dp.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// imhdk_dp
// Datapath: heap memories, size, walk registers, compares and result register.
// ----------------------------------------------------------------------------
module imhdk_dp (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  input  wire logic                                 cfg_wr_en,
  input  wire logic [imhdk_pkg::CountBits-1:0]      cfg_wr_data,
  input  wire logic [1:0]                           func,
  input  wire logic [imhdk_pkg::VertexBits-1:0]     vertex,
  input  wire logic [imhdk_pkg::KeyBits-1:0]        key,
  input  wire imhdk_pkg::cmd_t                      cmd,
  output imhdk_pkg::stat_t                          st,
  output logic                                      out_valid,
  input  wire logic                                 out_stall,
  output logic [1:0]                                status,
  output logic [imhdk_pkg::VertexBits-1:0]          out_vertex,
  output logic [imhdk_pkg::KeyBits-1:0]             out_key,
  output logic                                      in_heap,
  output logic                                      heap_empty
);

  localparam int VB = imhdk_pkg::VertexBits;
  localparam int PB = imhdk_pkg::PosBits;
  localparam int KB = imhdk_pkg::KeyBits;
  localparam int CB = imhdk_pkg::CountBits;

  logic [CB-1:0] vertex_count;
  logic [CB-1:0] size;
  logic [CB-1:0] cnt;
  logic [CB-1:0] load_n;
  logic [1:0]    func_reg;
  logic [VB-1:0] v_reg;
  logic [KB-1:0] key_reg;

  // walk registers
  logic [VB-1:0] idx;
  logic [VB-1:0] cv;
  logic [KB-1:0] ck;
  logic [VB-1:0] root;
  logic [VB-1:0] lastv;
  logic [VB-1:0] lv;
  logic [VB-1:0] rv;
  logic [KB-1:0] lk;
  logic [VB-1:0] pv;
  logic [VB-1:0] best;
  logic [PB-1:0] p;
  logic [KB-1:0] oldk;

  // pending result
  logic [1:0]    res_status;
  logic [VB-1:0] res_vertex;
  logic [KB-1:0] res_key;
  logic          res_inh;

  // memory ports
  logic          slot_we, pos_we, key_we;
  logic [VB-1:0] slot_waddr, slot_raddr, slot_wdata, slot_rd;
  logic [VB-1:0] pos_waddr, pos_raddr;
  logic [PB-1:0] pos_wdata, pos_rd;
  logic [VB-1:0] key_waddr, key_raddr;
  logic [KB-1:0] key_wdata, key_rd;

  logic [VB-1:0] last;
  logic [CB-1:0] lchild;
  logic [CB:0]   rchild;
  logic [VB-1:0] par;
  logic          take_l, take_r;
  logic [KB-1:0] bk;
  logic [VB-1:0] bv, bidx;
  logic          present;

  assign load_n  = (vertex_count > CB'(imhdk_pkg::MaxVertices))
                   ? CB'(imhdk_pkg::MaxVertices) : vertex_count;
  assign last    = VB'(size - CB'(1));
  assign lchild  = {idx, 1'b1};
  assign rchild  = {1'b0, lchild} + (CB+1)'(1);
  assign par     = VB'((idx - VB'(1)) >> 1);
  assign take_l  = lk < ck;
  assign bk      = take_l ? lk : ck;
  assign take_r  = (rchild < {1'b0, size}) && (key_rd < bk);
  assign bv      = take_r ? rv : lv;
  assign bidx    = take_r ? VB'(rchild) : (take_l ? VB'(lchild) : idx);
  assign present = (p < PB'(size)) && (slot_rd == v_reg);

  always_comb begin
    st.func      = imhdk_pkg::func_t'(cmd.accept ? func : func_reg);
    st.ld_more   = cnt < load_n;
    st.empty     = size == '0;
    st.no_child  = lchild >= size;
    st.keep      = !take_l && !take_r;
    st.present   = present;
    st.smaller   = key_reg < oldk;
    st.at_root   = idx == '0;
    st.parent_ok = !(ck < key_rd);
    st.out_free  = !out_valid || !out_stall;
  end

  always_comb begin
    slot_we    = 1'b0;
    slot_waddr = '0;
    slot_wdata = '0;
    slot_raddr = '0;
    pos_we     = 1'b0;
    pos_waddr  = '0;
    pos_wdata  = '0;
    pos_raddr  = '0;
    key_we     = 1'b0;
    key_waddr  = '0;
    key_wdata  = '0;
    key_raddr  = '0;
    unique case (cmd.op)
      imhdk_pkg::OP_LOAD: begin
        slot_we    = st.ld_more;
        slot_waddr = VB'(cnt);
        slot_wdata = VB'(cnt);
        pos_we     = st.ld_more;
        pos_waddr  = VB'(cnt);
        pos_wdata  = PB'(cnt);
        key_we     = st.ld_more;
        key_waddr  = VB'(cnt);
        key_wdata  = key_reg;
      end
      imhdk_pkg::OP_X1: slot_raddr = '0;
      imhdk_pkg::OP_X2: begin
        key_raddr  = slot_rd;
        slot_raddr = last;
      end
      imhdk_pkg::OP_X3: begin
        slot_we    = 1'b1;
        slot_waddr = '0;
        slot_wdata = slot_rd;
        pos_we     = 1'b1;
        pos_waddr  = slot_rd;
        pos_wdata  = '0;
      end
      imhdk_pkg::OP_X4: begin
        slot_we    = 1'b1;
        slot_waddr = last;
        slot_wdata = root;
        pos_we     = 1'b1;
        pos_waddr  = root;
        pos_wdata  = PB'(last);
        key_raddr  = lastv;
      end
      imhdk_pkg::OP_D1: slot_raddr = VB'(lchild);
      imhdk_pkg::OP_D2: begin
        key_raddr  = slot_rd;
        slot_raddr = VB'(rchild);
      end
      imhdk_pkg::OP_D3: key_raddr = slot_rd;
      imhdk_pkg::OP_D4: begin
        slot_we    = !st.keep;
        slot_waddr = idx;
        slot_wdata = bv;
        pos_we     = !st.keep;
        pos_waddr  = bv;
        pos_wdata  = PB'(idx);
      end
      imhdk_pkg::OP_D5, imhdk_pkg::OP_U4: begin
        slot_we    = 1'b1;
        slot_waddr = (cmd.op == imhdk_pkg::OP_D5) ? best : par;
        slot_wdata = cv;
        pos_we     = 1'b1;
        pos_waddr  = cv;
        pos_wdata  = PB'((cmd.op == imhdk_pkg::OP_D5) ? best : par);
      end
      imhdk_pkg::OP_K1: begin
        pos_raddr = v_reg;
        key_raddr = v_reg;
      end
      imhdk_pkg::OP_K2: slot_raddr = VB'(pos_rd);
      imhdk_pkg::OP_K3: begin
        key_we    = (func_reg == imhdk_pkg::FUNC_DEC_KEY) && present && (key_reg < oldk);
        key_waddr = v_reg;
        key_wdata = key_reg;
      end
      imhdk_pkg::OP_U1: slot_raddr = par;
      imhdk_pkg::OP_U2: key_raddr = slot_rd;
      imhdk_pkg::OP_U3: begin
        slot_we    = !st.parent_ok;
        slot_waddr = idx;
        slot_wdata = pv;
        pos_we     = !st.parent_ok;
        pos_waddr  = pv;
        pos_wdata  = PB'(idx);
      end
      default: begin
      end
    endcase
  end

  // st.smaller compares key_reg against oldk, captured from key_rd in K2 and used in K3
  always_ff @(posedge clk) begin
    if (rst) begin
      vertex_count <= CB'(imhdk_pkg::MaxVertices);
      size         <= '0;
      out_valid    <= 1'b0;
    end else begin
      if (cfg_wr_en) vertex_count <= cfg_wr_data;
      if (cmd.op == imhdk_pkg::OP_FIN && st.out_free) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
      if (cmd.op == imhdk_pkg::OP_LOAD && !st.ld_more) size <= load_n;
      if (cmd.op == imhdk_pkg::OP_X4) size <= size - CB'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      func_reg   <= func;
      v_reg      <= vertex;
      key_reg    <= key;
      cnt        <= '0;
      res_status <= (func == imhdk_pkg::FUNC_EXTRACT && size == '0)
                    ? imhdk_pkg::ST_EMPTY : imhdk_pkg::ST_OK;
      res_vertex <= (func == imhdk_pkg::FUNC_DEC_KEY || func == imhdk_pkg::FUNC_MEMBER)
                    ? vertex : '0;
      res_key    <= '0;
      res_inh    <= 1'b0;
    end
    unique case (cmd.op)
      imhdk_pkg::OP_LOAD: if (st.ld_more) cnt <= cnt + CB'(1);
      imhdk_pkg::OP_X2: root <= slot_rd;
      imhdk_pkg::OP_X3: begin
        res_vertex <= root;
        res_key    <= key_rd;
        lastv      <= slot_rd;
      end
      imhdk_pkg::OP_X4: begin
        cv  <= lastv;
        idx <= '0;
      end
      imhdk_pkg::OP_X5: ck <= key_rd;
      imhdk_pkg::OP_D2: lv <= slot_rd;
      imhdk_pkg::OP_D3: begin
        lk <= key_rd;
        rv <= slot_rd;
      end
      imhdk_pkg::OP_D4: best <= bidx;
      imhdk_pkg::OP_D5: idx <= best;
      imhdk_pkg::OP_K2: begin
        p    <= pos_rd;
        oldk <= key_rd;
      end
      imhdk_pkg::OP_K3: begin
        res_key <= oldk;
        res_inh <= present;
        if (func_reg == imhdk_pkg::FUNC_DEC_KEY) begin
          if (!present) begin
            res_status <= imhdk_pkg::ST_ABSENT;
          end else if (!(key_reg < oldk)) begin
            res_status <= imhdk_pkg::ST_NOT_SMALLER;
          end else begin
            res_key <= key_reg;
            idx     <= VB'(p);
            cv      <= v_reg;
            ck      <= key_reg;
          end
        end
      end
      imhdk_pkg::OP_U2: pv <= slot_rd;
      imhdk_pkg::OP_U4: idx <= par;
      imhdk_pkg::OP_FIN: begin
        if (st.out_free) begin
          status     <= res_status;
          out_vertex <= res_vertex;
          out_key    <= res_key;
          in_heap    <= res_inh;
          heap_empty <= size == '0;
        end
      end
      default: begin
      end
    endcase
  end

  imhdk_ram #(.WIDTH(VB), .DEPTH(imhdk_pkg::MaxVertices)) u_slot_ram (
    .clk   (clk),
    .we    (slot_we),
    .waddr (slot_waddr),
    .wdata (slot_wdata),
    .raddr (slot_raddr),
    .rdata (slot_rd)
  );

  imhdk_ram #(.WIDTH(PB), .DEPTH(imhdk_pkg::MaxVertices)) u_pos_ram (
    .clk   (clk),
    .we    (pos_we),
    .waddr (pos_waddr),
    .wdata (pos_wdata),
    .raddr (pos_raddr),
    .rdata (pos_rd)
  );

  imhdk_ram #(.WIDTH(KB), .DEPTH(imhdk_pkg::MaxVertices)) u_key_ram (
    .clk   (clk),
    .we    (key_we),
    .waddr (key_waddr),
    .wdata (key_wdata),
    .raddr (key_raddr),
    .rdata (key_rd)
  );

endmodule
`default_nettype wire

>>> rtl/imhdk_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// imhdk_checker
// Port-level checks of the heap core, bound to the top level.
// ----------------------------------------------------------------------------
module imhdk_checker (
  input wire logic                             clk,
  input wire logic                             rst,
  input wire logic                             in_valid,
  input wire logic                             in_stall,
  input wire logic                             out_valid,
  input wire logic                             out_stall,
  input wire logic [1:0]                       status,
  input wire logic [imhdk_pkg::VertexBits-1:0] out_vertex,
  input wire logic [imhdk_pkg::KeyBits-1:0]    out_key,
  input wire logic                             in_heap,
  input wire logic                             heap_empty
);

  // a stalled result stays up
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid)
    else $error("result dropped under stall");

  // every result follows an input transfer, so none shows right after reset
  a_reset: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result after reset");

  a_empty: assert property (@(posedge clk) disable iff (rst)
    out_valid && status == imhdk_pkg::ST_EMPTY |->
      heap_empty && !in_heap && out_vertex == '0 && out_key == '0)
    else $error("empty extract result malformed");

  a_absent: assert property (@(posedge clk) disable iff (rst)
    out_valid && status == imhdk_pkg::ST_ABSENT |-> !in_heap)
    else $error("absent vertex reported in heap");

  a_not_smaller: assert property (@(posedge clk) disable iff (rst)
    out_valid && status == imhdk_pkg::ST_NOT_SMALLER |-> in_heap && !heap_empty)
    else $error("rejected key on vertex outside heap");

endmodule

bind indexed_min_heap_decrease_key_core imhdk_checker u_imhdk_checker (.*);
`default_nettype wire
